// ===== hdl/gtf_pkg.sv =====
// ---------------------------------------------------------------------------
// gtf_pkg
// Shared codes and field widths of the grouped team queue.
// ---------------------------------------------------------------------------
`default_nettype none

package gtf_pkg;

    localparam int FUNC_W    = 2;
    localparam int ELEM_W    = 20;
    localparam int TEAM_ID_W = 10;
    localparam int STATUS_W  = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    // operation codes
    localparam func_t FUNC_ENQ = 2'd0;
    localparam func_t FUNC_DEQ = 2'd1;
    localparam func_t FUNC_CLR = 2'd2;

    // result status codes
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_DEQ   = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/gtf_if.sv =====
// ---------------------------------------------------------------------------
// gtf channel interfaces
// Valid/ready channels for operation beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface gtf_item_if import gtf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    func_t                func;
    logic [ELEM_W-1:0]    element;
    logic [TEAM_ID_W-1:0] team_id;

    modport source (output valid, func, element, team_id, input ready);
    modport sink   (input valid, func, element, team_id, output ready);
endinterface

interface gtf_result_if import gtf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] out_element;
    status_t           status;

    modport source (output valid, out_element, status, input ready);
    modport sink   (input valid, out_element, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/gtf_team_map.sv =====
// ---------------------------------------------------------------------------
// gtf_team_map
// Folds a team id into the range of configured teams (id modulo TEAMS).
// ---------------------------------------------------------------------------
`default_nettype none

module gtf_team_map import gtf_pkg::*; #(
    parameter int TEAMS = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic [TEAM_ID_W-1:0]       team_id,
    output logic      [$clog2(TEAMS)-1:0]   team
);

    localparam int TW = $clog2(TEAMS);

    logic [TEAM_ID_W-1:0] raw_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            raw_reg <= team_id;
        end
    end

    generate
        if (TEAMS >= 2**TEAM_ID_W)
        begin : g_direct
            // every id already names a team
            assign team = TW'(raw_reg);
        end
        else
        begin : g_fold
            // quotient by reciprocal multiply, exact for every 10-bit id
            localparam int RS  = TEAM_ID_W + TW;
            localparam int RM  = (2**RS + TEAMS - 1) / TEAMS;
            localparam int RMW = $clog2(RM + 1);
            localparam int PW  = TEAM_ID_W + RMW;

            logic [PW-1:0]        prod;
            logic [TEAM_ID_W-1:0] q_reg;
            logic [TEAM_ID_W-1:0] rem;

            assign prod = PW'(team_id) * PW'(RM);

            always_ff @(posedge clk)
            begin
                if (load)
                begin
                    q_reg <= TEAM_ID_W'(prod >> RS);
                end
            end

            assign rem  = raw_reg - TEAM_ID_W'(q_reg * TEAMS);
            assign team = TW'(rem);
        end
    endgenerate

endmodule

`default_nettype wire

// ===== hdl/grouped_team_fifo.sv =====
// ---------------------------------------------------------------------------
// grouped_team_fifo
// Team queue over a shared linked-list element store with a free list.
// ---------------------------------------------------------------------------
// usage
//   item beats carry func (enqueue, dequeue, clear), element and team_id;
//   every beat produces exactly one result beat (out_element, status).
//   one operation is in flight at a time; a finished result sits in an
//   output register so the next item can be taken while it waits.
// steps, from the accepting edge to the result register load
//   enqueue   decode, record update, then tail link if team is waiting
//   dequeue   decode, order fifo, team record, then link and value reads
//   full, empty, clear, unused code: decode only
//   each step is one dependent read or write of a registered-read memory;
//   no new item is taken before the last one reaches the result register
// reset and clear
//   after reset, and after every clear, a pass zeroes all TEAMS team
//   records; no item is accepted during it (the clear's own result
//   is still delivered). untouched slots of the store are tracked by a
//   high-water mark, so the free list needs no initial pass.
// stalls
//   while the result register is full and result.ready is low, the block
//   holds the finished result and takes no further item.
// ---------------------------------------------------------------------------
`default_nettype none

module grouped_team_fifo import gtf_pkg::*; #(
    parameter int TEAMS      = 1024,
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gtf_item_if.sink     item,
    gtf_result_if.source result
);

    localparam int TW  = $clog2(TEAMS);
    localparam int OCW = $clog2(TEAMS + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int UCW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_OP       = 3'd1;
    localparam logic [2:0] S_ENQ_UPD  = 3'd2;
    localparam logic [2:0] S_ENQ_LINK = 3'd3;
    localparam logic [2:0] S_DEQ_TEAM = 3'd4;
    localparam logic [2:0] S_DEQ_HEAD = 3'd5;
    localparam logic [2:0] S_DEQ_UPD  = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    typedef struct packed {
        logic          waiting;
        logic [AW-1:0] head;
        logic [AW-1:0] tail;
    } team_word_t;

    // memories
    logic [AW-1:0]         link_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] value_mem [CAPACITY];
    team_word_t            team_mem  [TEAMS];
    logic [TW-1:0]         order_mem [TEAMS];

    logic [AW-1:0]         link_q;
    logic [VALUE_BITS-1:0] value_q;
    team_word_t            team_q;
    logic [TW-1:0]         order_q;

    logic                  link_we;
    logic [AW-1:0]         link_waddr;
    logic [AW-1:0]         link_wdata;
    logic [AW-1:0]         link_raddr;
    logic                  value_we;
    logic [AW-1:0]         value_raddr;
    logic                  team_we;
    logic [TW-1:0]         team_waddr;
    team_word_t            team_wdata;
    logic [TW-1:0]         team_raddr;
    logic                  order_we;

    // control and payload registers
    logic [2:0]            state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [VALUE_BITS-1:0] elem_reg, elem_next;
    logic [AW-1:0]         free_head_reg, free_head_next;
    logic [UCW-1:0]        used_reg, used_next;
    logic [UCW-1:0]        hw_reg, hw_next;
    logic [TW-1:0]         rp_reg, rp_next;
    logic [TW-1:0]         wp_reg, wp_next;
    logic [OCW-1:0]        ocount_reg, ocount_next;
    logic                  sweep_busy_reg, sweep_busy_next;
    logic [TW-1:0]         sweep_idx_reg, sweep_idx_next;
    logic [TW-1:0]         team_reg, team_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [ELEM_W-1:0]     res_element_reg, res_element_next;
    status_t               res_status_reg, res_status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0]     out_element_reg, out_element_next;
    status_t               out_status_reg, out_status_next;

    logic                  accept;
    logic [TW-1:0]         team_red;
    logic                  slot_untouched;
    logic [AW-1:0]         slot_succ;
    logic [AW-1:0]         link_val;

    assign item.ready         = (state_reg == S_IDLE) && !sweep_busy_reg;
    assign accept             = item.valid && item.ready;
    assign result.valid       = out_valid_reg;
    assign result.out_element = out_element_reg;
    assign result.status      = out_status_reg;

    gtf_team_map #(
        .TEAMS (TEAMS)
    ) u_team_map (
        .clk     (clk),
        .load    (accept),
        .team_id (item.team_id),
        .team    (team_red)
    );

    // slots at or above the high-water mark were never written: their link
    // is the initial free chain, slot + 1 wrapping to zero
    assign slot_untouched = UCW'(slot_reg) >= hw_reg;
    assign slot_succ      = (slot_reg == AW'(CAPACITY - 1)) ? '0 : slot_reg + 1'b1;
    assign link_val       = slot_untouched ? slot_succ : link_q;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[slot_reg] <= elem_reg;
        end
        value_q <= value_mem[value_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (team_we)
        begin
            team_mem[team_waddr] <= team_wdata;
        end
        team_q <= team_mem[team_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (order_we)
        begin
            order_mem[wp_reg] <= team_reg;
        end
        order_q <= order_mem[rp_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        elem_next        = elem_reg;
        free_head_next   = free_head_reg;
        used_next        = used_reg;
        hw_next          = hw_reg;
        rp_next          = rp_reg;
        wp_next          = wp_reg;
        ocount_next      = ocount_reg;
        sweep_busy_next  = sweep_busy_reg;
        sweep_idx_next   = sweep_idx_reg;
        team_next        = team_reg;
        slot_next        = slot_reg;
        tail_next        = tail_reg;
        res_element_next = res_element_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg;
        out_element_next = out_element_reg;
        out_status_next  = out_status_reg;

        link_we     = 1'b0;
        link_waddr  = slot_reg;
        link_wdata  = '0;
        link_raddr  = slot_reg;
        value_we    = 1'b0;
        value_raddr = slot_reg;
        team_we     = 1'b0;
        team_waddr  = team_reg;
        team_wdata  = '0;
        team_raddr  = team_reg;
        order_we    = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        // zero pass over the team records after reset or clear
        if (sweep_busy_reg)
        begin
            team_we        = 1'b1;
            team_waddr     = sweep_idx_reg;
            team_wdata     = '0;
            sweep_idx_next = sweep_idx_reg + 1'b1;
            if (sweep_idx_reg == TW'(TEAMS - 1))
            begin
                sweep_busy_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = item.func;
                    elem_next  = VALUE_BITS'(item.element);
                    state_next = S_OP;
                end
            end

            S_OP:
            begin
                res_element_next = '0;
                res_status_next  = ST_DONE;
                state_next       = S_RESP;
                case (func_reg)
                    FUNC_ENQ:
                    begin
                        if (used_reg >= UCW'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            slot_next  = free_head_reg;
                            link_raddr = free_head_reg;
                            team_raddr = team_red;
                            team_next  = team_red;
                            state_next = S_ENQ_UPD;
                        end
                    end
                    FUNC_DEQ:
                    begin
                        if (ocount_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_DEQ_TEAM;
                        end
                    end
                    FUNC_CLR:
                    begin
                        free_head_next  = '0;
                        used_next       = '0;
                        hw_next         = '0;
                        rp_next         = '0;
                        wp_next         = '0;
                        ocount_next     = '0;
                        sweep_busy_next = 1'b1;
                        sweep_idx_next  = '0;
                    end
                    default:
                    begin
                        res_status_next = ST_DONE;
                    end
                endcase
            end

            S_ENQ_UPD:
            begin
                free_head_next = link_val;
                if (slot_untouched)
                begin
                    hw_next = hw_reg + 1'b1;
                end
                value_we   = 1'b1;
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = '0;
                team_we    = 1'b1;
                team_waddr = team_reg;
                team_wdata.waiting = 1'b1;
                team_wdata.head    = team_q.waiting ? team_q.head : slot_reg;
                team_wdata.tail    = slot_reg;
                if (!team_q.waiting && (ocount_reg < OCW'(TEAMS)))
                begin
                    order_we    = 1'b1;
                    wp_next     = (wp_reg == TW'(TEAMS - 1)) ? '0 : wp_reg + 1'b1;
                    ocount_next = ocount_reg + 1'b1;
                end
                used_next = used_reg + 1'b1;
                tail_next = team_q.tail;
                state_next = team_q.waiting ? S_ENQ_LINK : S_RESP;
            end

            S_ENQ_LINK:
            begin
                // chain the new slot behind the old tail of the team
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
                state_next = S_RESP;
            end

            S_DEQ_TEAM:
            begin
                team_next  = order_q;
                team_raddr = order_q;
                state_next = S_DEQ_HEAD;
            end

            S_DEQ_HEAD:
            begin
                slot_next   = team_q.head;
                tail_next   = team_q.tail;
                value_raddr = team_q.head;
                link_raddr  = team_q.head;
                state_next  = S_DEQ_UPD;
            end

            S_DEQ_UPD:
            begin
                team_we    = 1'b1;
                team_waddr = team_reg;
                team_wdata.tail = tail_reg;
                if (slot_reg == tail_reg)
                begin
                    // last element: the team leaves the order
                    team_wdata.waiting = 1'b0;
                    team_wdata.head    = slot_reg;
                    rp_next     = (rp_reg == TW'(TEAMS - 1)) ? '0 : rp_reg + 1'b1;
                    ocount_next = ocount_reg - 1'b1;
                end
                else
                begin
                    team_wdata.waiting = 1'b1;
                    team_wdata.head    = link_val;
                end
                link_we        = 1'b1;
                link_waddr     = slot_reg;
                link_wdata     = free_head_reg;
                free_head_next = slot_reg;
                if (used_reg != '0)
                begin
                    used_next = used_reg - 1'b1;
                end
                res_element_next = ELEM_W'(value_q);
                res_status_next  = ST_DEQ;
                state_next       = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_element_next = res_element_reg;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            used_reg       <= '0;
            hw_reg         <= '0;
            rp_reg         <= '0;
            wp_reg         <= '0;
            ocount_reg     <= '0;
            sweep_busy_reg <= 1'b1;
            sweep_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            used_reg       <= used_next;
            hw_reg         <= hw_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            ocount_reg     <= ocount_next;
            sweep_busy_reg <= sweep_busy_next;
            sweep_idx_reg  <= sweep_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        elem_reg        <= elem_next;
        team_reg        <= team_next;
        slot_reg        <= slot_next;
        tail_reg        <= tail_next;
        res_element_reg <= res_element_next;
        res_status_reg  <= res_status_next;
        out_element_reg <= out_element_next;
        out_status_reg  <= out_status_next;
    end

    // empty team order means the pointers have met
    a_order_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (ocount_reg == '0) |-> (rp_reg == wp_reg))
        else $error("team order empty but pointers differ");

    // slots in use never outnumber the high-water mark
    a_used_hw: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= hw_reg)
        else $error("more slots in use than ever allocated");

    // an untouched free head must be the next fresh slot
    a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
        ((used_reg < UCW'(CAPACITY)) && (UCW'(free_head_reg) >= hw_reg))
        |-> (UCW'(free_head_reg) == hw_reg))
        else $error("free list points past the fresh region");

    // an accepted beat starts decoding in the next cycle
    a_accept_op: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> (state_reg == S_OP))
        else $error("accepted beat not decoded");

endmodule

`default_nettype wire

// ===== tb/grouped_team_fifo_tb.sv =====
// ---------------------------------------------------------------------------
// grouped_team_fifo_tb
// Self-checking bench for the team queue. A predictor keeps one value queue
// per team and an order of waiting teams, and every result beat is checked
// against it. Directed cases come first, then random traffic. The random part
// includes a fill to a full store and a drain past empty. Both channels idle
// in random bursts, off in some of the mixed traffic and in the final stretch.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grouped_team_fifo_tb;
    import gtf_pkg::*;

    localparam int     TEAM_COUNT  = 1024;
    localparam int     SLOT_COUNT  = 1024;
    localparam func_t  FUNC_UNUSED = 2'd3;
    localparam int     MIXED_ITEMS = 200;
    localparam int     CALM_ITEMS  = 80;

    typedef struct packed {
        logic [ELEM_W-1:0] element;
        status_t           status;
    } team_result_t;

    class team_queue_checker;
        logic [ELEM_W-1:0] team_values [TEAM_COUNT][$];
        int unsigned       waiting_teams [$];
        team_result_t      expected_results [$];
        int                occupancy;
        int                errors;
        int                n_items, n_dequeued, n_full, n_empty, n_clear, n_checked;

        // work out the result of one accepted operation beat
        function void note_item(func_t f, logic [ELEM_W-1:0] e, logic [TEAM_ID_W-1:0] t);
            team_result_t r;
            int unsigned  tm;
            r.element = '0;
            r.status  = ST_DONE;
            n_items++;
            case (f)
                FUNC_ENQ:
                begin
                    if (occupancy >= SLOT_COUNT)
                    begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        tm = int'(t) % TEAM_COUNT;
                        if (team_values[tm].size() == 0)
                            waiting_teams.push_back(tm);
                        team_values[tm].push_back(e);
                        occupancy++;
                    end
                end
                FUNC_DEQ:
                begin
                    if (waiting_teams.size() == 0)
                    begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        tm        = waiting_teams[0];
                        r.element = team_values[tm].pop_front();
                        r.status  = ST_DEQ;
                        // team leaves the order once its own queue runs dry
                        if (team_values[tm].size() == 0)
                            void'(waiting_teams.pop_front());
                        occupancy--;
                        n_dequeued++;
                    end
                end
                FUNC_CLR:
                begin
                    foreach (team_values[i])
                        team_values[i].delete();
                    waiting_teams.delete();
                    occupancy = 0;
                    n_clear++;
                end
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [ELEM_W-1:0] e, status_t s);
            team_result_t want;
            n_checked++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (element %05h status %0d)",
                         $time, e, s);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (s !== want.status)
            begin
                $display("%0t: status mismatch, expected %0d got %0d", $time, want.status, s);
                errors++;
            end
            if (e !== want.element)
            begin
                $display("%0t: out_element mismatch, expected %05h got %05h",
                         $time, want.element, e);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   sink_stall;
    team_queue_checker board;

    gtf_item_if   item_ch ();
    gtf_result_if result_ch ();

    grouped_team_fifo #(
        .TEAMS      (TEAM_COUNT),
        .CAPACITY   (SLOT_COUNT),
        .VALUE_BITS (ELEM_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one operation beat; valid is left high so back-to-back beats need no toggle
    task automatic put_op(func_t f, logic [ELEM_W-1:0] e, logic [TEAM_ID_W-1:0] t);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.func    <= f;
        item_ch.element <= e;
        item_ch.team_id <= t;
        do
            @(posedge clk);
        while (!item_ch.ready);
        board.note_item(f, e, t);
    endtask

    function automatic logic [TEAM_ID_W-1:0] pick_team();
        // mostly a handful of teams so sub-queues grow long
        if ($urandom_range(0, 3) != 0)
            return TEAM_ID_W'($urandom_range(0, 11));
        return TEAM_ID_W'($urandom_range(0, TEAM_COUNT - 1));
    endfunction

    task automatic random_op(int enq_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 1)
            put_op(FUNC_CLR, ELEM_W'($urandom), TEAM_ID_W'($urandom));
        else if (r < 4)
            put_op(FUNC_UNUSED, ELEM_W'($urandom), TEAM_ID_W'($urandom));
        else if (r < 4 + enq_weight)
            put_op(FUNC_ENQ, ELEM_W'($urandom), pick_team());
        else
            put_op(FUNC_DEQ, ELEM_W'($urandom), TEAM_ID_W'($urandom));
    endtask

    // result side: check every beat, stall ready in random bursts
    initial
    begin
        sink_stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                board.check_result(result_ch.out_element, result_ch.status);
            if (sink_stall == 0 && gaps_on && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 17);
            if (sink_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_stall--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int weight;
        board = new();
        gaps_on = 1'b1;
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.func    <= FUNC_ENQ;
        item_ch.element <= '0;
        item_ch.team_id <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty, field extremes, team rejoining the order, unused code, clear
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_ENQ, 20'h00000, 10'd0);
        put_op(FUNC_ENQ, 20'hFFFFF, 10'd1023);
        put_op(FUNC_ENQ, 20'h12345, 10'd0);
        put_op(FUNC_ENQ, 20'hABCDE, 10'd5);
        put_op(FUNC_UNUSED, 20'hFFFFF, 10'd1023);
        put_op(FUNC_DEQ, 20'hFFFFF, 10'd1023);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_ENQ, 20'h77777, 10'd0);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_ENQ, 20'h55555, 10'd1023);
        put_op(FUNC_ENQ, 20'hAAAAA, 10'd512);
        put_op(FUNC_CLR, 20'hFFFFF, 10'd1023);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);
        put_op(FUNC_ENQ, 20'h5A5A5, 10'd1);
        put_op(FUNC_DEQ, 20'h00000, 10'd0);

        // mixed traffic, the enqueue share moving so occupancy drifts up and down
        for (int i = 0; i < MIXED_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                weight  = 30 + 20 * $urandom_range(0, 2);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            random_op(weight);
        end

        // fill the store, poke the full boundary, then drain past empty
        gaps_on = 1'b1;
        while (board.occupancy < SLOT_COUNT)
            put_op(FUNC_ENQ, ELEM_W'($urandom),
                   $urandom_range(0, 1) ? pick_team() : TEAM_ID_W'($urandom));
        put_op(FUNC_ENQ, ELEM_W'($urandom), pick_team());
        put_op(FUNC_DEQ, '0, '0);
        put_op(FUNC_ENQ, ELEM_W'($urandom), pick_team());
        put_op(FUNC_ENQ, ELEM_W'($urandom), pick_team());
        while (board.occupancy > 0)
            put_op(FUNC_DEQ, ELEM_W'($urandom), TEAM_ID_W'($urandom));
        put_op(FUNC_DEQ, '0, '0);
        put_op(FUNC_DEQ, '0, '0);

        // final stretch at full rate
        gaps_on = 1'b0;
        for (int i = 0; i < CALM_ITEMS; i++)
            random_op(50);
        item_ch.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d operation beats, %0d result beats checked",
                 board.n_items, board.n_checked);
        $display("dequeued %0d, empty %0d, store full %0d, clears %0d",
                 board.n_dequeued, board.n_empty, board.n_full, board.n_clear);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== grouped_team_fifo.f =====
hdl/gtf_pkg.sv
hdl/gtf_if.sv
hdl/gtf_team_map.sv
hdl/grouped_team_fifo.sv
tb/grouped_team_fifo_tb.sv
